// ===== hw/rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the rational arithmetic unit.
// No dependencies; every other file imports this package.
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int WIDE = 64;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MOD    = 3'd2,
    OP_MUL    = 3'd3,
    OP_INVERT = 3'd4,
    OP_REDUCE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_MODZ = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G1,
    S_Q1,
    S_Q2,
    S_ML,
    S_MX,
    S_MY,
    S_COMB,
    S_MOD,
    S_PM1,
    S_PM2,
    S_EPREP,
    S_EG,
    S_EN,
    S_ED,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/rau_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the operand beat and the result beat.
// Depends on rau_pkg.
interface rau_in_if import rau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] a_num;
  logic [30:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  modport source(output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if ();
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic [1:0]  status;
  modport source(output valid, res_num, res_den, status, input ready);
  modport sink(input valid, res_num, res_den, status, output ready);
endinterface

// ===== hw/rtl/rau_divider.sv =====
`timescale 1ns / 1ps
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the word width.
module rau_divider import rau_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WIDE-1:0] num,
  input  logic [WIDE-1:0] den,
  output logic            busy,
  output logic            done,
  output logic [WIDE-1:0] quo,
  output logic [WIDE-1:0] rem
);

  logic [WIDE:0]   part;
  logic [WIDE-1:0] dvs;
  logic [5:0]      cnt;
  logic [WIDE:0]   trial;

  assign trial = {part[WIDE-1:0], quo[WIDE-1]};
  assign rem   = part[WIDE-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        part <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        // shift in the next dividend bit, subtract where it fits
        if (trial >= {1'b0, dvs}) begin
          part <= trial - {1'b0, dvs};
          quo  <= {quo[WIDE-2:0], 1'b1};
        end else begin
          part <= trial;
          quo  <= {quo[WIDE-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(WIDE - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: sequencer, shared divider, multiplier.
// Depends on rau_pkg, rau_if and rau_divider.
//
// One request beat carries an operation and two fractions a and b; one result beat
// returns the result reduced to lowest terms, sign on the numerator, with a status
// code (zero denominator, modulo by zero). The block handles one request at a time:
// in_ch.ready is high only while idle. Every gcd step, every reduction and the lcm
// quotients run on a single 64-bit restoring divider. Reduce and invert need one gcd;
// multiply adds two multiplies; add, subtract and modulo need a gcd of the denominators,
// two quotients, three multiplies and, for modulo, one more division before the final
// reduction. Euclid's loop takes up to about 45 steps on the 31-bit denominators and
// about 90 steps for 63-bit values, so a worst case bounds at about 140 divisions.
// Undefined operation codes return 0/1 at once.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  localparam int W = OPERAND_WIDTH;

  state_t state, state_next;

  // decoded request beat
  logic [W-1:0] av, bv;
  logic         dec_an, dec_bn;
  logic [31:0]  dec_am, dec_bm;
  logic [30:0]  dec_ad, dec_bd;
  logic         in_fire, out_fire;

  assign av     = in_ch.a_num[W-1:0];
  assign bv     = in_ch.b_num[W-1:0];
  assign dec_an = av[W-1];
  assign dec_bn = bv[W-1];
  assign dec_am = 32'(dec_an ? (~av + 1'b1) : av);
  assign dec_bm = 32'(dec_bn ? (~bv + 1'b1) : bv);
  assign dec_ad = 31'(in_ch.a_den[W-2:0]);
  assign dec_bd = 31'(in_ch.b_den[W-2:0]);

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  // held operands and working registers
  op_t          op;
  logic         an, bn, eneg;
  logic [31:0]  am, bm;
  logic [30:0]  ad, bd;
  logic [31:0]  q1, q2;
  logic [63:0]  gx, gy, lcm, xm, ym, em, ed;
  logic [63:0]  res_num;
  logic [62:0]  res_den;
  status_t      res_status;
  logic         div_go;

  // shared divider
  logic        div_start, div_busy, div_done;
  logic [63:0] div_n, div_d, div_q, div_r;

  rau_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_n),
    .den  (div_d),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_q),
    .rem  (div_r)
  );

  // shared multiplier, result registered by the consuming state
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    mul_a = am;
    mul_b = bm;
    case (state)
      S_ML:    begin mul_a = q1;         mul_b = 32'(bd); end
      S_MX:    begin mul_a = am;         mul_b = q2;      end
      S_MY:    begin mul_a = bm;         mul_b = q1;      end
      S_PM2:   begin mul_a = 32'(ad);    mul_b = 32'(bd); end
      default: begin mul_a = am;         mul_b = bm;      end
    endcase
  end

  // divider operand select
  always_comb begin
    div_n = gx;
    div_d = gy;
    case (state)
      S_Q1:    begin div_n = 64'(ad); div_d = gx; end
      S_Q2:    begin div_n = 64'(bd); div_d = gx; end
      S_MOD:   begin div_n = xm;      div_d = ym; end
      S_EN:    begin div_n = em;      div_d = gx; end
      S_ED:    begin div_n = ed;      div_d = gx; end
      default: begin div_n = gx;      div_d = gy; end
    endcase
  end

  logic gcd_state, div_state;
  assign gcd_state = (state == S_G1) || (state == S_EG);
  assign div_state = (state == S_Q1) || (state == S_Q2) || (state == S_MOD) ||
                     (state == S_EN) || (state == S_ED);
  // launch once per division; a gcd step launches only while gy is nonzero
  assign div_start = !div_go && (div_state || (gcd_state && gy != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type > 3'(OP_REDUCE)) begin
            state_next = S_OUT;
          end else if (dec_ad == '0 ||
                       (in_ch.req_type <= 3'(OP_MUL) && dec_bd == '0)) begin
            state_next = S_OUT;
          end else if (in_ch.req_type == 3'(OP_MUL)) begin
            state_next = S_PM1;
          end else if (in_ch.req_type inside {OP_INVERT, OP_REDUCE}) begin
            state_next = S_EPREP;
          end else begin
            state_next = S_G1;
          end
        end
      end
      S_G1:    if (gy == '0) state_next = S_Q1;
      S_Q1:    if (div_done) state_next = S_Q2;
      S_Q2:    if (div_done) state_next = S_ML;
      S_ML:    state_next = S_MX;
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_COMB;
      S_COMB:  begin
        if (op == OP_MOD) begin
          state_next = (bm == '0) ? S_OUT : S_MOD;
        end else begin
          state_next = S_EPREP;
        end
      end
      S_MOD:   if (div_done) state_next = S_EPREP;
      S_PM1:   state_next = S_PM2;
      S_PM2:   state_next = S_EPREP;
      S_EPREP: state_next = (em == '0 || ed == '0) ? S_OUT : S_EG;
      S_EG:    if (gy == '0) state_next = S_EN;
      S_EN:    if (div_done) state_next = S_ED;
      S_ED:    if (div_done) state_next = S_OUT;
      S_OUT:   if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      if (div_start) div_go <= 1'b1;
      if (div_done)  div_go <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op         <= op_t'(in_ch.req_type);
          an         <= dec_an;
          bn         <= dec_bn;
          am         <= dec_am;
          bm         <= dec_bm;
          ad         <= dec_ad;
          bd         <= dec_bd;
          gx         <= 64'(dec_ad);
          gy         <= 64'(dec_bd);
          eneg       <= dec_an;
          res_num    <= '0;
          res_den    <= 63'd1;
          res_status <= ST_OK;
          if (in_ch.req_type <= 3'(OP_REDUCE) &&
              (dec_ad == '0 || (in_ch.req_type <= 3'(OP_MUL) && dec_bd == '0)))
            res_status <= ST_ZDEN;
          // invert swaps numerator and denominator, the sign stays
          if (in_ch.req_type == 3'(OP_INVERT)) begin
            em <= 64'(dec_ad);
            ed <= 64'(dec_am);
          end else begin
            em <= 64'(dec_am);
            ed <= 64'(dec_ad);
          end
        end
      end
      S_G1, S_EG: begin
        if (div_done) begin
          gx <= gy;
          gy <= div_r;
        end
      end
      S_Q1:  if (div_done) q1 <= div_q[31:0];
      S_Q2:  if (div_done) q2 <= div_q[31:0];
      S_ML:  lcm <= prod;
      S_MX:  xm  <= prod;
      S_MY:  ym  <= prod;
      S_COMB: begin
        ed <= lcm;
        if (op == OP_MOD) begin
          if (bm == '0) res_status <= ST_MODZ;
        end else if (an == (bn ^ (op == OP_SUB))) begin
          em <= xm + ym;
        end else if (xm >= ym) begin
          em <= xm - ym;
        end else begin
          em   <= ym - xm;
          eneg <= ~an;
        end
      end
      S_MOD: if (div_done) em <= div_r;
      S_PM1: begin
        em   <= prod;
        eneg <= an ^ bn;
      end
      S_PM2: ed <= prod;
      S_EPREP: begin
        gx <= em;
        gy <= ed;
      end
      S_EN: if (div_done) em <= div_q;
      S_ED: begin
        if (div_done) begin
          res_num <= eneg ? (~em + 64'd1) : em;
          res_den <= div_q[62:0];
        end
      end
      default: ;
    endcase
  end

  assign out_ch.res_num = res_num;
  assign out_ch.res_den = res_den;
  assign out_ch.status  = res_status;

  // a result beat never carries a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.res_den != '0) else $error("zero result denominator");

  // the divider is launched only when free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider launched while busy");

  // a flagged result is always 0/1
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.res_num == '0 &&
      out_ch.res_den == 63'd1)) else $error("flagged result not 0/1");

  // a division completes only while a division state waits for it
  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_state || gcd_state)) else $error("orphan divider result");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rational_arithmetic_unit: random and corner fractions,
// predicted results compared beat by beat. Depends on rau_pkg, rau_if and the RTL.
module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] an;
    logic [30:0] ad;
    logic [31:0] bn;
    logic [30:0] bd;
  } frac_req_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  st;
  } frac_res_t;

  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  frac_req_t  pending_reqs[$];
  frac_res_t  expected_fracs[$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_seen = 0;
  bit         quiet_phase = 0;
  bit         drain_pause = 0;
  int         hold_long = 0;
  int         idle_cycles = 0;
  int         op_hits[8];

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduce sign/magnitude over den to lowest terms; zero gives 0/1.
  function automatic frac_res_t reduce_frac(bit neg, logic [63:0] mag, logic [63:0] den,
                                            logic [1:0] st);
    frac_res_t r;
    logic [63:0] g;
    r.st = st;
    if (mag == 0 || den == 0) begin
      r.num = 0;
      r.den = 1;
      return r;
    end
    g = euclid(mag, den);
    mag = mag / g;
    den = den / g;
    r.num = neg ? -mag : mag;
    r.den = den[62:0];
    return r;
  endfunction

  function automatic frac_res_t predict_frac(frac_req_t q);
    bit an_neg, bn_neg, xn, yn;
    logic [63:0] am, bm, ad, bd, g, l, xm, ym;
    an_neg = q.an[31];
    bn_neg = q.bn[31];
    am = an_neg ? {32'd0, -q.an} : {32'd0, q.an};
    bm = bn_neg ? {32'd0, -q.bn} : {32'd0, q.bn};
    ad = {33'd0, q.ad};
    bd = {33'd0, q.bd};
    if (q.op > OP_REDUCE) return reduce_frac(0, 0, 1, ST_OK);
    if (ad == 0 || (q.op <= OP_MUL && bd == 0)) return reduce_frac(0, 0, 1, ST_ZDEN);
    case (q.op)
      OP_REDUCE: return reduce_frac(an_neg, am, ad, ST_OK);
      OP_INVERT: return reduce_frac(an_neg, ad, am, ST_OK);
      OP_MUL:    return reduce_frac(an_neg != bn_neg, am * bm, ad * bd, ST_OK);
      default: begin
      end
    endcase
    g = euclid(ad, bd);
    l = (ad / g) * bd;
    xm = am * (l / ad);
    ym = bm * (l / bd);
    xn = an_neg;
    yn = bn_neg;
    if (q.op == OP_MOD) begin
      if (bm == 0) return reduce_frac(0, 0, 1, ST_MODZ);
      return reduce_frac(xn, xm % ym, l, ST_OK);
    end
    if (q.op == OP_SUB) yn = !yn;
    if (xn == yn) return reduce_frac(xn, xm + ym, l, ST_OK);
    if (xm >= ym) return reduce_frac(xn, xm - ym, l, ST_OK);
    return reduce_frac(yn, ym - xm, l, ST_OK);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %0h want %0h", n_seen, what, got, want);
    errors++;
  endtask

  // Pick a numerator: mostly small, sometimes full range or corners.
  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return 32'($urandom);
      default: return 32'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 31'h7fff_ffff;
      2, 3: return 31'($urandom);
      default: return 31'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic push_req(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                          logic [31:0] bn, logic [30:0] bd);
    frac_req_t q;
    q.op = op; q.an = an; q.ad = ad; q.bn = bn; q.bd = bd;
    pending_reqs.push_back(q);
  endtask

  // Driver: present the head of the queue at the falling edge; random gaps.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (drain_pause || pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= pending_reqs[0].op;
        in_ch.a_num    <= pending_reqs[0].an;
        in_ch.a_den    <= pending_reqs[0].ad;
        in_ch.b_num    <= pending_reqs[0].bn;
        in_ch.b_den    <= pending_reqs[0].bd;
      end
    end
  end

  // Accept beats at the rising edge: retire them from the queue, queue predictions.
  always @(posedge clk) begin
    frac_req_t q;
    if (!rst && in_ch.valid && in_ch.ready) begin
      q.op = in_ch.req_type; q.an = in_ch.a_num; q.ad = in_ch.a_den;
      q.bn = in_ch.b_num; q.bd = in_ch.b_den;
      expected_fracs.push_back(predict_frac(q));
      op_hits[q.op]++;
      void'(pending_reqs.pop_front());
      n_sent++;
      if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
    end
  end

  // Monitor: compare each result beat against the oldest prediction.
  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_seen++;
      if (expected_fracs.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_ch.res_num, '0);
      end else begin
        want = expected_fracs.pop_front();
        if (out_ch.res_num !== want.num) report_mismatch("res_num", out_ch.res_num, want.num);
        if (out_ch.res_den !== want.den)
          report_mismatch("res_den", 64'(out_ch.res_den), 64'(want.den));
        if (out_ch.status !== want.st)
          report_mismatch("status", 64'(out_ch.status), 64'(want.st));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off requested by the stimulus.
  int rcv_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_long > 0) begin
      hold_long <= hold_long - 1;
      out_ch.ready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 6) == 0) rcv_gap <= $urandom_range(1, 18);
    end
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Watchdog expired with %0d results outstanding", expected_fracs.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int tail;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0; in_ch.a_num = '0; in_ch.a_den = '0;
    in_ch.b_num = '0; in_ch.b_den = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every operation, extremes, zero denominators, modulo by zero,
    // invert of zero, zero result and the unused selectors.
    push_req(OP_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_fffe);
    push_req(OP_SUB, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_fffe);
    push_req(OP_SUB, 3, 4, 3, 4);
    push_req(OP_ADD, 1, 3, -1, 6);
    push_req(OP_MOD, 7, 2, 3, 4);
    push_req(OP_MOD, -7, 2, 3, 4);
    push_req(OP_MOD, 32'h8000_0000, 1, -1, 1);
    push_req(OP_MOD, 5, 3, 0, 7);
    push_req(OP_MOD, 5, 0, 0, 7);
    push_req(OP_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_fffe);
    push_req(OP_MUL, -6, 35, 14, 9);
    push_req(OP_MUL, 1, 2, 1, 0);
    push_req(OP_INVERT, 0, 5, 1, 0);
    push_req(OP_INVERT, -4, 6, 9, 9);
    push_req(OP_INVERT, 32'h8000_0000, 31'h7fff_ffff, 0, 0);
    push_req(OP_REDUCE, -84, 36, 0, 0);
    push_req(OP_REDUCE, 0, 99, 3, 3);
    push_req(OP_REDUCE, 5, 0, 3, 3);
    push_req(OP_ADD, 0, 0, 0, 0);
    push_req(3'd6, 3, 4, 5, 6);
    push_req(3'd7, -1, 31'h7fff_ffff, -1, 31'h7fff_ffff);
    push_req(OP_ADD, 32'hffff_ffff, 31'h5555_5555, 32'h5555_5555, 31'h2aaa_aaaa);

    // Random traffic; partway through, a stretch where the receiver holds off long.
    for (int i = 0; i < 1500; i++) begin
      logic [2:0] op;
      op = 3'(($urandom_range(0, 40) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
      push_req(op, pick_num(), pick_den(), pick_num(), pick_den());
      if (i == 200) begin
        wait (pending_reqs.size() <= 1300);
        @(negedge clk);
        hold_long = 3000;
      end
      if (i == 700) begin
        // Stop offering until every outstanding result is back.
        wait (pending_reqs.size() <= 1);
        @(negedge clk);
        drain_pause = 1;
        wait (pending_reqs.size() == 1 || pending_reqs.size() == 0);
        wait (expected_fracs.size() == 0 && !(in_ch.valid && in_ch.ready));
        repeat ($urandom_range(5, 40)) @(negedge clk);
        drain_pause = 0;
      end
      if (i == 1300) begin
        wait (pending_reqs.size() <= 100);
        quiet_phase = 1;
      end
    end

    wait (pending_reqs.size() == 0);
    wait (expected_fracs.size() == 0);
    tail = 0;
    while (tail < 500) begin
      @(posedge clk);
      tail++;
    end

    $display("Covered %0d requests: add %0d sub %0d mod %0d mul %0d inv %0d red %0d other %0d",
             n_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
             op_hits[6] + op_hits[7]);
    $display("Results checked: %0d, mismatches: %0d", n_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
